>>> design/gwcg_pkg.sv
// Shared constants and types of the grid window connectivity generator.
`timescale 1ns / 1ps
package gwcg_pkg;

  localparam int MAX_WINDOW_DIM = 7;
  localparam int MAX_GRID_DIM   = 1024;
  localparam int WEIGHT_BITS    = 16;

  localparam int TAP_DEPTH = MAX_WINDOW_DIM * MAX_WINDOW_DIM;
  localparam int TAP_AW    = $clog2(TAP_DEPTH);

  localparam int POS_W  = 10;
  localparam int DIM_W  = 11;
  localparam int HALF_W = 2;
  localparam int TAP_W  = 3;
  localparam int IDX_W  = 21;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 64;
  localparam int CFG_AW     = 4;

  localparam logic [1:0] REG_HALF_ROWS = 2'd0;
  localparam logic [1:0] REG_HALF_COLS = 2'd1;
  localparam logic [1:0] REG_GRID_ROWS = 2'd2;
  localparam logic [1:0] REG_GRID_COLS = 2'd3;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EMIT = 1'b1;

  typedef logic signed [WEIGHT_BITS-1:0] weight_t;

endpackage

>>> design/gwcg_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module gwcg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 49
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/grid_window_connectivity_gen_core.sv
// Top level of the grid window connectivity generator: control, walk and output stage.
//
//   channel | ports                    | direction | carries
//   --------+--------------------------+-----------+-----------------------------------
//   in      | in_tvalid/tready/tdata/  | slave     | weight load or centre position
//           | tuser                    |           |
//   out     | out_tvalid/tready/tdata/ | master    | source, neighbour, weight triplets
//           | tlast                    |           |
//   cfg     | cfg_psel ... cfg_pready  | APB slave | window halves and grid size
//
// A weight load or an out-of-range position leaves the core idle. A position in range goes
// through setup states S_MUL (index multiply) and S_BASE (column base), then a walk that
// reads up to 49 neighbour weights one by one through the single read port of the weight
// memory. No new item is taken until the walk ends.
// rst_n is synchronous; the weight memory is not cleared and must be loaded before use.
// A low out_tready stalls the walk once stage one and the output register both hold a triplet.
`timescale 1ns / 1ps
module grid_window_connectivity_gen_core
  import gwcg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata: tap_row[2:0], tap_col[5:3], tap_weight[21:6], grid_row[31:22],
  // grid_col[41:32], zero fill[47:42]
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // in_tuser: mode[0]
  input  logic                  in_tuser,
  // out_tdata: source_index[20:0], neighbour_index[41:21], weight[57:42], zero fill[63:58]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_AW-1:0]     cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_BASE = 4'b0100,
    S_WALK = 4'b1000
  } state_t;

  // Configuration registers
  logic [HALF_W-1:0] half_rows_r, half_cols_r;
  logic [DIM_W-1:0]  grid_rows_r, grid_cols_r;
  logic              cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_rows_r <= HALF_W'(1);
      half_cols_r <= HALF_W'(1);
      grid_rows_r <= DIM_W'(MAX_GRID_DIM);
      grid_cols_r <= DIM_W'(MAX_GRID_DIM);
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_HALF_ROWS: half_rows_r <= cfg_pwdata[HALF_W-1:0];
        REG_HALF_COLS: half_cols_r <= cfg_pwdata[HALF_W-1:0];
        REG_GRID_ROWS: grid_rows_r <= cfg_pwdata[DIM_W-1:0];
        REG_GRID_COLS: grid_cols_r <= cfg_pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_HALF_ROWS: cfg_prdata = {{(32-HALF_W){1'b0}}, half_rows_r};
      REG_HALF_COLS: cfg_prdata = {{(32-HALF_W){1'b0}}, half_cols_r};
      REG_GRID_ROWS: cfg_prdata = {{(32-DIM_W){1'b0}}, grid_rows_r};
      REG_GRID_COLS: cfg_prdata = {{(32-DIM_W){1'b0}}, grid_cols_r};
      default:       cfg_prdata = '0;
    endcase
  end

  // Input fields
  logic              in_mode;
  logic [TAP_W-1:0]  in_tap_row, in_tap_col;
  weight_t           in_tap_weight;
  logic [POS_W-1:0]  in_grid_row, in_grid_col;
  logic [DIM_W-1:0]  rows_eff, cols_eff;
  logic              in_acc;

  assign in_mode       = in_tuser;
  assign in_tap_row    = in_tdata[2:0];
  assign in_tap_col    = in_tdata[5:3];
  assign in_tap_weight = in_tdata[21:6];
  assign in_grid_row   = in_tdata[31:22];
  assign in_grid_col   = in_tdata[41:32];

  // Grid sizes above the maximum count as the maximum.
  assign rows_eff = (grid_rows_r > DIM_W'(MAX_GRID_DIM)) ? DIM_W'(MAX_GRID_DIM) : grid_rows_r;
  assign cols_eff = (grid_cols_r > DIM_W'(MAX_GRID_DIM)) ? DIM_W'(MAX_GRID_DIM) : grid_cols_r;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid & in_tready;

  // Weight memory. Loads are only taken while idle and reads only happen in the walk,
  // so a read and a write never meet on the same entry.
  logic              ram_we, ram_re;
  logic [TAP_AW-1:0] ram_waddr, ram_raddr;
  weight_t           ram_rdata;

  assign ram_we    = in_acc && (in_mode == MODE_LOAD) &&
                     (in_tap_row < TAP_W'(MAX_WINDOW_DIM)) &&
                     (in_tap_col < TAP_W'(MAX_WINDOW_DIM));
  assign ram_waddr = TAP_AW'(in_tap_row) * TAP_AW'(MAX_WINDOW_DIM) + TAP_AW'(in_tap_col);

  gwcg_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (TAP_DEPTH)
  ) u_tap_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_tap_weight),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Walk context
  logic [POS_W-1:0]  cr_r, cc_r;
  logic [DIM_W-1:0]  rows_r;
  logic [HALF_W-1:0] hr_r, hc_r;
  logic [POS_W-1:0]  r_lo_r, r_hi_r, c_lo_r, c_hi_r;
  logic [POS_W-1:0]  r_cur_r, c_cur_r;
  logic [IDX_W-1:0]  prod_r, src_r, col_base_r;

  logic [DIM_W-1:0]  cr_plus, cc_plus, rows_m1, cols_m1;
  logic [DIM_W-1:0]  cols_r;
  logic [HALF_W-1:0] col_off;
  logic [DIM_W-1:0]  dr_full, dc_full;
  logic [TAP_W-1:0]  dr, dc;
  logic              row_end, col_end, walk_last;

  // Output pipeline
  logic             p1_valid_r, p1_last_r, p1_move, issue;
  logic [IDX_W-1:0] p1_src_r, p1_nbr_r;
  logic             out_valid_r, out_last_r;
  logic [IDX_W-1:0] out_src_r, out_nbr_r;
  weight_t          out_w_r;

  assign cr_plus = DIM_W'(cr_r) + DIM_W'(hr_r);
  assign cc_plus = DIM_W'(cc_r) + DIM_W'(hc_r);
  assign rows_m1 = rows_r - DIM_W'(1);
  assign cols_m1 = cols_r - DIM_W'(1);
  assign col_off = HALF_W'(cc_r - c_lo_r);

  // Offsets into the window always lie in 0..6, so the low bits suffice.
  assign dr_full   = DIM_W'(r_cur_r) + DIM_W'(hr_r) - DIM_W'(cr_r);
  assign dc_full   = DIM_W'(c_cur_r) + DIM_W'(hc_r) - DIM_W'(cc_r);
  assign dr        = dr_full[TAP_W-1:0];
  assign dc        = dc_full[TAP_W-1:0];
  assign ram_raddr = TAP_AW'(dr) * TAP_AW'(MAX_WINDOW_DIM) + TAP_AW'(dc);

  assign row_end   = (r_cur_r == r_hi_r);
  assign col_end   = (c_cur_r == c_hi_r);
  assign walk_last = row_end & col_end;

  assign p1_move = p1_valid_r & (~out_valid_r | out_tready);
  assign issue   = (state_r == S_WALK) & (~p1_valid_r | p1_move);
  assign ram_re  = issue;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_mode == MODE_EMIT) &&
            (DIM_W'(in_grid_row) < rows_eff) && (DIM_W'(in_grid_col) < cols_eff)) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL:  state_nxt = S_BASE;
      S_BASE: state_nxt = S_WALK;
      S_WALK: begin
        if (issue && walk_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cr_r   <= in_grid_row;
      cc_r   <= in_grid_col;
      rows_r <= rows_eff;
      cols_r <= cols_eff;
      hr_r   <= half_rows_r;
      hc_r   <= half_cols_r;
    end
    if (state_r == S_MUL) begin
      prod_r <= IDX_W'(cc_r) * IDX_W'(rows_r);
      r_lo_r <= (cr_r >= POS_W'(hr_r)) ? (cr_r - POS_W'(hr_r)) : '0;
      c_lo_r <= (cc_r >= POS_W'(hc_r)) ? (cc_r - POS_W'(hc_r)) : '0;
      r_hi_r <= (cr_plus > rows_m1) ? rows_m1[POS_W-1:0] : cr_plus[POS_W-1:0];
      c_hi_r <= (cc_plus > cols_m1) ? cols_m1[POS_W-1:0] : cc_plus[POS_W-1:0];
    end
    if (state_r == S_BASE) begin
      // Step back from the centre column to the first column of the window.
      col_base_r <= prod_r - IDX_W'(col_off) * IDX_W'(rows_r);
      src_r      <= prod_r + IDX_W'(cr_r) + IDX_W'(1);
      r_cur_r    <= r_lo_r;
      c_cur_r    <= c_lo_r;
    end else if (issue) begin
      if (row_end) begin
        r_cur_r    <= r_lo_r;
        c_cur_r    <= c_cur_r + POS_W'(1);
        col_base_r <= col_base_r + IDX_W'(rows_r);
      end else begin
        r_cur_r <= r_cur_r + POS_W'(1);
      end
    end
  end

  // Stage one waits on the memory read; the output register holds the item offered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (issue) begin
        p1_valid_r <= 1'b1;
      end else if (p1_move) begin
        p1_valid_r <= 1'b0;
      end
      if (p1_move) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      p1_src_r  <= src_r;
      p1_nbr_r  <= col_base_r + IDX_W'(r_cur_r) + IDX_W'(1);
      p1_last_r <= walk_last;
    end
    if (p1_move) begin
      out_src_r  <= p1_src_r;
      out_nbr_r  <= p1_nbr_r;
      out_w_r    <= ram_rdata;
      out_last_r <= p1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(OUT_DATA_W-2*IDX_W-WEIGHT_BITS){1'b0}}, out_w_r, out_nbr_r, out_src_r};

  // Assertions
  a_ram_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !ram_re && (state_r == S_IDLE))
    else $error("weight memory written while the walk reads it");

  a_p1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    p1_valid_r && !p1_move |=> p1_valid_r && $stable(p1_nbr_r) && $stable(ram_rdata))
    else $error("pending item lost while the output stalls");

  a_last_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
    issue && walk_last |=> state_r == S_IDLE)
    else $error("walk continues after its last neighbour");

  a_index_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_src_r != '0) && (out_nbr_r != '0))
    else $error("one-based index is zero");

endmodule
